[rtl/avpg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Attribute video pixel generator package
// Shared command codes, field widths and color constants.
// ----------------------------------------------------------------------------
package avpg_pkg;

  // Command codes carried by each input beat.
  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_BORDER    = 2'd1,
    CMD_FRAME_END = 2'd2,
    CMD_RENDER    = 2'd3
  } cmd_t;

  // Field widths. The line number width covers the shortest allowed line
  // length; the column width covers the longest.
  localparam int CLK_W  = 17;
  localparam int LINE_W = 11;
  localparam int CO_W   = 10;
  localparam int ADDR_W = 13;

  // Display memory layout.
  localparam int          MEM_DEPTH    = 6912;
  localparam int          BITMAP_LINES = 192;
  localparam logic [ADDR_W-1:0] ATTR_BASE = 13'h1800;

  // Attribute byte bits.
  localparam int ATTR_FLASH_BIT  = 7;
  localparam int ATTR_BRIGHT_BIT = 6;

  // Color intensities.
  localparam logic [7:0] LEVEL_DIM    = 8'hD8;
  localparam logic [7:0] LEVEL_BRIGHT = 8'hFF;

endpackage
`default_nettype wire

[rtl/attribute_video_pixel_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Attribute video pixel generator
// Bitmap-plus-attribute video generator with a colored border.
// ----------------------------------------------------------------------------
// A beat enters a four-stage pipe: input register, reciprocal multiply,
// line and column split with the display memory access, and the pixel
// stage. A render beat that lands in a drawn position holds the pixel stage
// until its second pixel is emitted, and the pipe does not advance before
// then; other beats do not hold it. While the pixel stage is free and the
// output is not stalled, beats are taken every cycle. The pixel stage is fed
// by the 6912-byte display RAM (one write port, two registered read ports
// for the bitmap and attribute bytes). The display RAM holds no reset value:
// every byte must be written before it is shown.
module attribute_video_pixel_generator #(
  parameter int LINE_CLOCKS         = 224,
  parameter int ACTIVE_CLOCKS       = 128,
  parameter int RIGHT_BORDER_CLOCKS = 24,
  parameter int RETRACE_CLOCKS      = 48,
  parameter int HIDDEN_LINES        = 16,
  parameter int TOP_BORDER_LINES    = 48
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [12:0] mem_offset,
  input  wire logic [7:0]  mem_data,
  input  wire logic [2:0]  border_value,
  input  wire logic [16:0] frame_clock,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [8:0]       pixel_x,
  output logic [8:0]       pixel_y,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic             last_of_pair
);

  localparam int ClkW   = avpg_pkg::CLK_W;
  localparam int LineW  = avpg_pkg::LINE_W;
  localparam int CoW    = avpg_pkg::CO_W;
  localparam int AddrW  = avpg_pkg::ADDR_W;
  localparam int MemDepth = avpg_pkg::MEM_DEPTH;

  // Timing landmarks, in clocks from the start of a line or frame, or in lines.
  localparam int RightEnd   = ACTIVE_CLOCKS + RIGHT_BORDER_CLOCKS;
  localparam int RetraceEnd = RightEnd + RETRACE_CLOCKS;
  localparam int LeftClocks = (LINE_CLOCKS > RetraceEnd) ? LINE_CLOCKS - RetraceEnd : 0;
  localparam int HiddenEnd  = HIDDEN_LINES * LINE_CLOCKS;
  localparam int BitmapEnd  = TOP_BORDER_LINES + avpg_pkg::BITMAP_LINES;
  localparam logic [8:0] LeftX    = 9'(2 * LeftClocks);
  localparam logic [8:0] LeftSkip = 9'(2 * RetraceEnd);
  localparam logic [LineW-1:0] HiddenL = LineW'(HIDDEN_LINES);
  localparam logic [LineW-1:0] TopL    = LineW'(TOP_BORDER_LINES);

  typedef enum logic [1:0] {
    RGN_BITMAP,
    RGN_RIGHT,
    RGN_LEFT
  } rgn_t;

  // Pipe control.
  logic adv;
  logic out_can;
  logic emit;
  logic in_take;

  // Input stage.
  logic                  a_valid;
  avpg_pkg::cmd_t        a_cmd;
  logic [AddrW-1:0]      a_off;
  logic [7:0]            a_data;
  logic [2:0]            a_border;
  logic [ClkW-1:0]       a_clk;

  // Multiply stage.
  logic                  b_valid;
  avpg_pkg::cmd_t        b_cmd;
  logic [AddrW-1:0]      b_off;
  logic [7:0]            b_data;
  logic [2:0]            b_border;
  logic                  b_hidden;

  // Split and memory stage.
  logic                  c_valid;
  avpg_pkg::cmd_t        c_cmd;
  logic [AddrW-1:0]      c_off;
  logic [7:0]            c_data;
  logic [2:0]            c_border;
  logic                  c_hidden;
  logic [LineW-1:0]      c_line;
  logic [CoW-1:0]        c_co;

  // Decode of the split stage.
  logic [LineW-1:0]      scan;
  logic [7:0]            bm_y;
  logic [4:0]            bm_col;
  logic [AddrW-1:0]      bm_addr;
  logic [AddrW-1:0]      at_addr;
  logic                  in_retrace;
  logic                  produce;
  rgn_t                  rgn;

  // Block state.
  logic [2:0]            border_colour;
  logic                  flash_invert;
  logic [3:0]            frame_counter;
  logic [7:0]            display_mem [MemDepth];

  // Pixel stage.
  logic                  d_valid;
  logic                  d_second;
  rgn_t                  d_rgn;
  logic [CoW-1:0]        d_co;
  logic [8:0]            d_scan;
  logic [2:0]            d_border;
  logic                  d_flash;
  logic [7:0]            bits_q;
  logic [7:0]            attr_q;

  // Pixel decode.
  logic [CoW:0]          px;
  logic                  fg;
  logic [2:0]            grb;
  logic [7:0]            lvl;
  logic [8:0]            pos_x;

  // Handshake: the pipe moves whenever the pixel stage is free or about
  // to release its second pixel; the input register also fills a bubble.
  assign out_can  = !out_valid || !out_stall;
  assign emit     = d_valid && out_can;
  assign adv      = !d_valid || (out_can && d_second);
  assign in_stall = a_valid && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv || in_take) begin
      a_valid <= in_take;
    end
    if (in_take) begin
      a_cmd    <= avpg_pkg::cmd_t'(command);
      a_off    <= mem_offset;
      a_data   <= mem_data;
      a_border <= border_value;
      a_clk    <= frame_clock;
    end
  end

  // Line and column split runs alongside the next two stages.
  avpg_clock_split #(
    .LINE_CLOCKS(LINE_CLOCKS)
  ) u_split (
    .clk         (clk),
    .en          (adv),
    .frame_clock (a_clk),
    .line        (c_line),
    .co          (c_co)
  );

  // Payload of the multiply and split stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
    if (adv) begin
      b_cmd    <= a_cmd;
      b_off    <= a_off;
      b_data   <= a_data;
      b_border <= a_border;
      b_hidden <= 32'(a_clk) < HiddenEnd;
      c_cmd    <= b_cmd;
      c_off    <= b_off;
      c_data   <= b_data;
      c_border <= b_border;
      c_hidden <= b_hidden;
    end
  end

  // Position decode and display memory addresses for a render beat.
  always_comb begin
    scan       = c_line - HiddenL;
    bm_y       = 8'(scan - TopL);
    bm_col     = c_co[6:2];
    bm_addr    = {bm_y[7:6], bm_y[2:0], bm_y[5:3], bm_col};
    at_addr    = avpg_pkg::ATTR_BASE | {3'b000, bm_y[7:3], bm_col};
    in_retrace = (32'(c_co) >= RightEnd) && (32'(c_co) < RetraceEnd);
    produce    = c_valid && (c_cmd == avpg_pkg::CMD_RENDER) && !c_hidden && !in_retrace;
    if ((32'(c_co) < ACTIVE_CLOCKS) && (32'(scan) >= TOP_BORDER_LINES) &&
        (32'(scan) < BitmapEnd)) begin
      rgn = RGN_BITMAP;
    end else if (32'(c_co) < RightEnd) begin
      rgn = RGN_RIGHT;
    end else begin
      rgn = RGN_LEFT;
    end
  end

  // Display memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (adv && c_valid && (c_cmd == avpg_pkg::CMD_WRITE) && (32'(c_off) < MemDepth)) begin
      display_mem[c_off] <= c_data;
    end
    if (adv) begin
      bits_q <= display_mem[bm_addr];
      attr_q <= display_mem[at_addr];
    end
  end

  // Border color, frame counter and flash phase, updated in beat order.
  always_ff @(posedge clk) begin
    if (rst) begin
      border_colour <= 3'd0;
      flash_invert  <= 1'b0;
      frame_counter <= 4'd0;
    end else if (adv && c_valid) begin
      case (c_cmd)
        avpg_pkg::CMD_BORDER: begin
          border_colour <= c_border;
        end
        avpg_pkg::CMD_FRAME_END: begin
          frame_counter <= frame_counter + 4'd1;
          if (frame_counter == 4'hF) begin
            flash_invert <= !flash_invert;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pixel stage: holds a render beat for its two pixels.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid  <= 1'b0;
      d_second <= 1'b0;
    end else if (adv) begin
      d_valid  <= produce;
      d_second <= 1'b0;
    end else if (emit) begin
      d_second <= 1'b1;
    end
    if (adv) begin
      d_rgn    <= rgn;
      d_co     <= c_co;
      d_scan   <= scan[8:0];
      d_border <= border_colour;
      d_flash  <= flash_invert;
    end
  end

  // Color and position of the current pixel.
  always_comb begin
    px = {d_co, d_second};
    fg = bits_q[~px[2:0]] ^ (attr_q[avpg_pkg::ATTR_FLASH_BIT] & d_flash);
    case (d_rgn)
      RGN_BITMAP: begin
        grb   = fg ? attr_q[2:0] : attr_q[5:3];
        lvl   = attr_q[avpg_pkg::ATTR_BRIGHT_BIT] ? avpg_pkg::LEVEL_BRIGHT
                                                   : avpg_pkg::LEVEL_DIM;
        pos_x = px[8:0] + LeftX;
      end
      RGN_RIGHT: begin
        grb   = d_border;
        lvl   = avpg_pkg::LEVEL_DIM;
        pos_x = px[8:0] + LeftX;
      end
      default: begin
        grb   = d_border;
        lvl   = avpg_pkg::LEVEL_DIM;
        pos_x = px[8:0] - LeftSkip;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      pixel_x      <= pos_x;
      pixel_y      <= d_scan;
      red          <= grb[1] ? lvl : 8'd0;
      green        <= grb[2] ? lvl : 8'd0;
      blue         <= grb[0] ? lvl : 8'd0;
      last_of_pair <= d_second;
    end
  end

endmodule
`default_nettype wire

[rtl/avpg_clock_split.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame clock splitter
// Splits a frame clock count into line number and clock within the line,
// using a reciprocal multiply in one stage and a single correction step in
// the next, with both stages advancing on en.
// ----------------------------------------------------------------------------
module avpg_clock_split #(
  parameter int LINE_CLOCKS = 224
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [avpg_pkg::CLK_W-1:0]   frame_clock,
  output logic      [avpg_pkg::LINE_W-1:0]  line,
  output logic      [avpg_pkg::CO_W-1:0]    co
);

  localparam int ClkW   = avpg_pkg::CLK_W;
  localparam int LineW  = avpg_pkg::LINE_W;
  localparam int CoW    = avpg_pkg::CO_W;
  // Reciprocal scaled by the full clock range, so the estimate is low by
  // at most one line.
  localparam int Recip  = (2 ** ClkW) / LINE_CLOCKS;
  localparam int RecipW = $clog2(Recip + 1);
  localparam int ProdW  = ClkW + RecipW;

  logic [ProdW-1:0] prod;
  logic [ClkW-1:0]  clk_b;
  logic [LineW-1:0] q_est;
  logic [ClkW-1:0]  rem;
  logic             corr;

  // First stage: reciprocal product.
  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= ProdW'(frame_clock) * ProdW'(Recip);
      clk_b <= frame_clock;
    end
  end

  // Second stage: remainder and one correction step.
  always_comb begin
    q_est = LineW'(prod >> ClkW);
    rem   = clk_b - ClkW'(q_est * LINE_CLOCKS);
    corr  = 32'(rem) >= LINE_CLOCKS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line <= q_est + LineW'(corr);
      co   <= corr ? CoW'(rem - ClkW'(LINE_CLOCKS)) : CoW'(rem);
    end
  end

endmodule
`default_nettype wire

[verif/attribute_video_pixel_generator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attribute video pixel generator testbench
// Drives command beats into the generator and checks every pixel beat that
// comes out against a cycle-free model of the frame: display memory, border
// color and flash state are tracked on each accepted beat, and the expected
// pixels are queued in order and compared field by field as they arrive.
// ----------------------------------------------------------------------------
module attribute_video_pixel_generator_tb;

  // Frame timing used for this build of the block.
  localparam int LINE_CLOCKS         = 224;
  localparam int ACTIVE_CLOCKS       = 128;
  localparam int RIGHT_BORDER_CLOCKS = 24;
  localparam int RETRACE_CLOCKS      = 48;
  localparam int HIDDEN_LINES        = 16;
  localparam int TOP_BORDER_LINES    = 48;

  localparam int DRAWN_CLOCKS = ACTIVE_CLOCKS + RIGHT_BORDER_CLOCKS;
  localparam int SWEEP_CLOCKS = DRAWN_CLOCKS + RETRACE_CLOCKS;
  localparam int LEFT_CLOCKS  = (LINE_CLOCKS > SWEEP_CLOCKS) ? LINE_CLOCKS - SWEEP_CLOCKS : 0;
  localparam int FIRST_SHOWN  = HIDDEN_LINES * LINE_CLOCKS;
  localparam int FRAME_CLOCKS = 312 * LINE_CLOCKS;
  localparam int CLOCK_MAX    = (1 << avpg_pkg::CLK_W) - 1;
  localparam int OFFSET_MAX   = (1 << avpg_pkg::ADDR_W) - 1;
  localparam int BM_LINES     = avpg_pkg::BITMAP_LINES;
  localparam int MEM_SIZE     = avpg_pkg::MEM_DEPTH;
  localparam int ATTR_START   = int'(avpg_pkg::ATTR_BASE);

  localparam int BEATS_PER_PHASE = 450;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 30;
  localparam int CYCLE_LIMIT     = 600000;

  typedef struct {
    logic [8:0] x;
    logic [8:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pair_end;
  } pixel_t;

  // Tracks display memory, border and flash state, and the pixels still owed.
  class pixel_scoreboard;
    logic [7:0] vram [MEM_SIZE];
    logic [2:0] border;
    bit         flash_on;
    logic [3:0] frames;
    pixel_t     pending [$];
    int         mismatches;

    function new();
      border     = '0;
      flash_on   = 1'b0;
      frames     = '0;
      mismatches = 0;
    endfunction

    // Returns 1 when the clock falls inside the bitmap, with the addresses of
    // the bitmap byte and attribute byte that both of its pixels use.
    function bit locate(input logic [16:0] fclk, output int bm_addr, output int at_addr);
      int c, co, scan, y, xb, ry;
      c = int'(fclk);
      co = c % LINE_CLOCKS;
      scan = c / LINE_CLOCKS - HIDDEN_LINES;
      bm_addr = 0;
      at_addr = 0;
      if (c < FIRST_SHOWN || co >= ACTIVE_CLOCKS || scan < TOP_BORDER_LINES ||
          scan >= TOP_BORDER_LINES + BM_LINES)
        return 1'b0;
      y  = scan - TOP_BORDER_LINES;
      xb = ((co * 2) >> 3) & 31;
      ry = (y & 'hC0) | ((y & 7) << 3) | ((y & 'h38) >> 3);
      bm_addr = xb | (ry << 5);
      at_addr = ATTR_START + xb + (y >> 3) * 32;
      return 1'b1;
    endfunction

    // Queues the two pixels of one render clock, if any are drawn.
    function void render(input logic [16:0] fclk);
      int c, co, scan, x, bm, at;
      bit in_bitmap;
      logic [7:0] bits, attr, lvl;
      logic [2:0] grb;
      logic fg;
      pixel_t p;
      c = int'(fclk);
      if (c < FIRST_SHOWN)
        return;
      co = c % LINE_CLOCKS;
      scan = c / LINE_CLOCKS - HIDDEN_LINES;
      if (co >= DRAWN_CLOCKS && co < SWEEP_CLOCKS)
        return;
      in_bitmap = locate(fclk, bm, at);
      if (in_bitmap) begin
        bits = vram[bm];
        attr = vram[at];
      end
      for (int i = 0; i < 2; i++) begin
        x   = co * 2 + i;
        lvl = avpg_pkg::LEVEL_DIM;
        grb = border;
        if (in_bitmap) begin
          fg = bits[7 - (x & 7)];
          if (attr[avpg_pkg::ATTR_FLASH_BIT] && flash_on)
            fg = ~fg;
          grb = fg ? attr[2:0] : attr[5:3];
          if (attr[avpg_pkg::ATTR_BRIGHT_BIT])
            lvl = avpg_pkg::LEVEL_BRIGHT;
        end
        // Left border pixels restart at x = 0; the rest sit after it.
        if (co < DRAWN_CLOCKS)
          p.x = 9'(2 * LEFT_CLOCKS + x);
        else
          p.x = 9'(x - 2 * SWEEP_CLOCKS);
        p.y        = 9'(scan);
        p.red      = grb[1] ? lvl : 8'h00;
        p.green    = grb[2] ? lvl : 8'h00;
        p.blue     = grb[0] ? lvl : 8'h00;
        p.pair_end = i[0];
        pending.push_back(p);
      end
    endfunction

    // Applies one accepted input beat.
    function void note_beat(input avpg_pkg::cmd_t cmd, input logic [12:0] offset,
                            input logic [7:0] data, input logic [2:0] bval,
                            input logic [16:0] fclk);
      case (cmd)
        avpg_pkg::CMD_WRITE: begin
          if (offset < MEM_SIZE)
            vram[offset] = data;
        end
        avpg_pkg::CMD_BORDER: begin
          border = bval;
        end
        avpg_pkg::CMD_FRAME_END: begin
          frames = frames + 4'd1;
          if (frames == 4'd0)
            flash_on = ~flash_on;
        end
        default: begin
          render(fclk);
        end
      endcase
    endfunction

    // Compares one accepted pixel beat with the oldest pixel owed.
    function void check_pixel(input pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: x=%0d y=%0d rgb=%h/%h/%h end=%0b",
                   got.x, got.y, got.red, got.green, got.blue, got.pair_end);
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue ||
          got.pair_end !== want.pair_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected x=%0d y=%0d rgb=%h/%h/%h end=%0b,",
                   want.x, want.y, want.red, want.green, want.blue, want.pair_end,
                   " got x=%0d y=%0d rgb=%h/%h/%h end=%0b",
                   got.x, got.y, got.red, got.green, got.blue, got.pair_end);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = avpg_pkg::CMD_WRITE;
  logic [12:0] mem_offset = '0;
  logic [7:0]  mem_data = '0;
  logic [2:0]  border_value = '0;
  logic [16:0] frame_clock = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  pixel_x;
  logic [8:0]  pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_of_pair;

  pixel_scoreboard sb;
  bit  mem_written [MEM_SIZE];
  int  send_idle_pct = 35;
  int  recv_idle_pct = 70;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  cycles = 0;
  int  beats_sent = 0;

  attribute_video_pixel_generator #(
    .LINE_CLOCKS         (LINE_CLOCKS),
    .ACTIVE_CLOCKS       (ACTIVE_CLOCKS),
    .RIGHT_BORDER_CLOCKS (RIGHT_BORDER_CLOCKS),
    .RETRACE_CLOCKS      (RETRACE_CLOCKS),
    .HIDDEN_LINES        (HIDDEN_LINES),
    .TOP_BORDER_LINES    (TOP_BORDER_LINES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .mem_offset   (mem_offset),
    .mem_data     (mem_data),
    .border_value (border_value),
    .frame_clock  (frame_clock),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .last_of_pair (last_of_pair)
  );

  always #10 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Pixel receiver: check each accepted beat, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_pixel('{pixel_x, pixel_y, red, green, blue, last_of_pair});
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offers one beat, with random idle cycles ahead of it, and waits for it
  // to be taken.
  task automatic send_beat(input avpg_pkg::cmd_t cmd, input logic [12:0] offset,
                           input logic [7:0] data, input logic [2:0] bval,
                           input logic [16:0] fclk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    mem_offset   <= offset;
    mem_data     <= data;
    border_value <= bval;
    frame_clock  <= fclk;
    do
      @(posedge clk);
    while (in_stall);
    beats_sent++;
    sb.note_beat(cmd, offset, data, bval, fclk);
    if (cmd == avpg_pkg::CMD_WRITE && offset < MEM_SIZE)
      mem_written[offset] = 1'b1;
  endtask

  task automatic write_byte(input int offset, input logic [7:0] data);
    send_beat(avpg_pkg::CMD_WRITE, 13'(offset), data, 3'($urandom), 17'($urandom));
  endtask

  task automatic other_beat(input avpg_pkg::cmd_t cmd, input logic [2:0] bval);
    send_beat(cmd, 13'($urandom), 8'($urandom), bval, 17'($urandom));
  endtask

  // Renders one clock. Bitmap positions first get any byte they read that
  // was never written, so no unwritten memory is ever shown.
  task automatic render_at(input int fclk);
    int bm, at;
    if (sb.locate(17'(fclk), bm, at)) begin
      if (!mem_written[bm])
        write_byte(bm, 8'($urandom));
      if (!mem_written[at])
        write_byte(at, 8'($urandom));
    end
    send_beat(avpg_pkg::CMD_RENDER, 13'($urandom), 8'($urandom), 3'($urandom), 17'(fclk));
  endtask

  // One random beat: mostly display writes and render clocks, with a share
  // aimed straight at the bitmap so most renders read real memory.
  task automatic random_beat();
    int sel, pick, line;
    sel = $urandom_range(99);
    if (sel < 30) begin
      if ($urandom_range(99) < 85)
        write_byte($urandom_range(MEM_SIZE - 1), 8'($urandom));
      else
        write_byte($urandom_range(OFFSET_MAX), 8'($urandom));
    end else if (sel < 38) begin
      other_beat(avpg_pkg::CMD_BORDER, 3'($urandom));
    end else if (sel < 45) begin
      other_beat(avpg_pkg::CMD_FRAME_END, 3'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        line = $urandom_range(HIDDEN_LINES + TOP_BORDER_LINES,
                              HIDDEN_LINES + TOP_BORDER_LINES + BM_LINES - 1);
        render_at(line * LINE_CLOCKS + $urandom_range(ACTIVE_CLOCKS - 1));
      end else if (pick < 90) begin
        render_at($urandom_range(FRAME_CLOCKS - 1));
      end else begin
        render_at($urandom_range(CLOCK_MAX));
      end
    end
  endtask

  initial begin
    int line20;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed beats: border, hidden and shown edges, bitmap corners,
    // ignored writes, every part of a line and clocks past the frame.
    other_beat(avpg_pkg::CMD_BORDER, 3'd7);
    render_at(0);
    render_at(FIRST_SHOWN - 1);
    render_at(FIRST_SHOWN);
    write_byte(0, 8'hA5);
    write_byte(ATTR_START, 8'hC7);
    render_at((HIDDEN_LINES + TOP_BORDER_LINES) * LINE_CLOCKS);
    write_byte(6143, 8'hFF);
    write_byte(MEM_SIZE - 1, 8'h3A);
    render_at((HIDDEN_LINES + TOP_BORDER_LINES + BM_LINES - 1) * LINE_CLOCKS +
              ACTIVE_CLOCKS - 1);
    write_byte(MEM_SIZE, 8'h00);
    write_byte(OFFSET_MAX, 8'hFF);
    line20 = 20 * LINE_CLOCKS;
    render_at(line20 + ACTIVE_CLOCKS);
    render_at(line20 + DRAWN_CLOCKS - 1);
    render_at(line20 + DRAWN_CLOCKS);
    render_at(line20 + SWEEP_CLOCKS - 1);
    render_at(line20 + SWEEP_CLOCKS);
    render_at(line20 + LINE_CLOCKS - 1);
    other_beat(avpg_pkg::CMD_FRAME_END, 3'd0);
    render_at(FRAME_CLOCKS - 1);
    render_at(CLOCK_MAX);
    other_beat(avpg_pkg::CMD_BORDER, 3'd0);

    // Each phase runs until the running beat count reaches its mark, so the
    // memory fills ahead of renders count toward the total.
    // Random beats with the sender idling less than the receiver.
    while (beats_sent < BEATS_PER_PHASE)
      random_beat();

    // Then the other way round.
    send_idle_pct = 70;
    recv_idle_pct = 35;
    while (beats_sent < 2 * BEATS_PER_PHASE)
      random_beat();

    // Then at full rate, with one long receiver hold-off a third of the way
    // through while beats keep coming, so the pipe backs up into the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (beats_sent < 2 * BEATS_PER_PHASE + BEATS_PER_PHASE / 3)
      random_beat();
    hold_req++;
    while (beats_sent < 3 * BEATS_PER_PHASE)
      random_beat();
    in_valid <= 1'b0;

    // Drain the pixels still owed, then watch for strays.
    while (sb.pending.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
